[design/sqll_pkg.sv]
// ----------------------------------------------------------------------------
// sqll_pkg
// Shared types and constants for the LIKE pattern matcher.
// ----------------------------------------------------------------------------
package sqll_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int NPOS        = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(NPOS);
  localparam int LEVELS      = $clog2(NPOS);

  localparam logic [7:0] PCT_CHAR = 8'd37;
  localparam logic [7:0] ONE_CHAR = 8'd95;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_VALUE  = 2'd2,
    FUNC_END    = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  // spread set bits upward through runs of pass bits, log-depth prefix
  function automatic logic [NPOS-1:0] close_set(input logic [NPOS-1:0] set_in,
                                                input logic [NPOS-1:0] pass_in);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] p;
    g = set_in;
    p = pass_in;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    return g;
  endfunction

endpackage

[design/sql_like_pattern_match.sv]
// ----------------------------------------------------------------------------
// sql_like_pattern_match
// LIKE matcher: pattern bytes are loaded into a register store, value bytes
// advance a bit-parallel set of active pattern positions.
// ----------------------------------------------------------------------------
// One word is taken each unstalled cycle, whatever its function: each value
// byte advances the active-position vector through one combinational step (a
// per-position byte compare plus a log-depth closure over '%'), so the rate
// is one word per unstalled clock. An end-of-value word's verdict is in the
// result register in the cycle after it is taken; the input stalls only while
// that register holds a result the receiver is stalling. A pattern longer than
// the store sets pattern_overflow and never matches until the next clear.
module sql_like_pattern_match
  import sqll_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [7:0]       store [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] len_mask;
  logic [MAX_PATTERN-1:0] pct_mask;
  logic [MAX_PATTERN-1:0] one_mask;
  logic [LEN_W-1:0] length;
  logic             overflow_flag;
  logic [NPOS-1:0]  active;          // positions before closure

  logic             accept;
  logic [NPOS-1:0]  pass;
  logic [NPOS-1:0]  closed;
  logic [NPOS-1:0]  active_next;
  logic             room;
  logic             hit;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;
  assign room       = length < LEN_W'(MAX_PATTERN);

  // a '%' at stored position i lets position i+1 join
  assign pass   = {pct_mask & len_mask, 1'b0};
  assign closed = close_set(active, pass);
  assign hit    = closed[length] & ~overflow_flag;

  always_comb begin
    active_next = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (closed[i] && len_mask[i]) begin
        if (pct_mask[i]) begin
          active_next[i] = 1'b1;
        end else if (one_mask[i] || store[i] == item.ch) begin
          active_next[i+1] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_mask      <= '0;
      length        <= '0;
      overflow_flag <= 1'b0;
      active        <= NPOS'(1);
    end else if (accept) begin
      unique case (item.func)
        FUNC_CLEAR: begin
          len_mask      <= '0;
          length        <= '0;
          overflow_flag <= 1'b0;
          active        <= NPOS'(1);
        end
        FUNC_APPEND: begin
          if (room) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
              if (length == LEN_W'(i)) begin
                len_mask[i] <= 1'b1;
              end
            end
            length <= length + LEN_W'(1);
          end else begin
            overflow_flag <= 1'b1;
          end
          active <= NPOS'(1);
        end
        FUNC_VALUE: begin
          active <= active_next;
        end
        FUNC_END: begin
          active <= NPOS'(1);
        end
        default: begin
          active <= NPOS'(1);
        end
      endcase
    end
  end

  // pattern bytes, written at the current length
  always_ff @(posedge clk) begin
    if (accept && item.func == FUNC_APPEND && room) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (length == LEN_W'(i)) begin
          store[i]    <= item.ch;
          pct_mask[i] <= item.ch == PCT_CHAR;
          one_mask[i] <= item.ch == ONE_CHAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && item.func == FUNC_END) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.func == FUNC_END) begin
      result.matched          <= hit;
      result.pattern_overflow <= overflow_flag;
    end
  end

  a_ovf_no_match: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pattern_overflow |-> !result.matched)
    else $error("match reported with overflowed pattern");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(MAX_PATTERN))
    else $error("pattern length beyond store");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && item.func == FUNC_CLEAR |=> length == '0 && !overflow_flag)
    else $error("clear did not empty the pattern");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    accept && item.func == FUNC_END |=> result_valid)
    else $error("end of value gave no result");

  a_len_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(len_mask) == int'(length))
    else $error("length mask out of step with length");

endmodule
